// ===== design/pidaw_pkg.sv =====
// Shared types, register indexes and saturation helpers for the PID controller.
package pidaw_pkg;

   localparam int DATA_W   = 32;
   localparam int PERIOD_W = 17;
   localparam int RATE_W   = 16;
   localparam int OP_W     = 33;
   localparam int PROD_W   = 2 * OP_W;
   localparam int ACC_W    = 34;
   localparam int FRAC_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_HIGH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_LOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_SCALE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE   = 3'd7;

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic                   load;
      logic                   shift;
      logic signed [OP_W-1:0] a;
      logic signed [OP_W-1:0] b;
   } pidaw_mul_req_type;

   function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > PROD_W'(Q_MAX)) begin
         r = Q_MAX;
      end else if (v < PROD_W'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > ACC_W'(Q_MAX)) begin
         r = Q_MAX;
      end else if (v < ACC_W'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/pidaw_mul_unit.sv =====
// Shared signed multiplier with registered product, optional Q16.16 floor shift and saturation.
module pidaw_mul_unit
   import pidaw_pkg::*;
(
   input  logic                     clock,
   input  pidaw_mul_req_type        mul_req,
   output logic signed [DATA_W-1:0] mul_result
);

   logic signed [OP_W-1:0]   op_a;
   logic signed [OP_W-1:0]   op_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     shift_ff;
   logic signed [PROD_W-1:0] shifted;

   assign op_a    = mul_req.a;
   assign op_b    = mul_req.b;
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (mul_req.load) begin
         prod_ff  <= prod_in;
         shift_ff <= mul_req.shift;
      end
   end

   always_comb begin
      if (shift_ff) begin
         shifted = prod_ff >>> FRAC_W;
      end else begin
         shifted = prod_ff;
      end
      mul_result = sat_prod(shifted);
   end

endmodule

// ===== design/pid_controller_antiwindup_top.sv =====
// PID controller with integral clamp: register file, sequencer and output register.
// An accepted item passes through states M1 to M6, SUM and OUT before its drive value appears on rsp_valid.
// A new item is accepted only once the last one has left OUT; the shared multiplier is used six times per item.
// Drive values wait in the output register; the last step holds only while one is still there.
// Reset is synchronous: integral, previous measurement and registers take their defaults.
module pid_controller_antiwindup_top
   import pidaw_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [DATA_W-1:0]    req_setpoint,
   input  logic signed [DATA_W-1:0]    req_measurement,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DATA_W-1:0]    rsp_drive,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_wdata
);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_M1   = 9'b000000010,
      S_M2   = 9'b000000100,
      S_M3   = 9'b000001000,
      S_M4   = 9'b000010000,
      S_M5   = 9'b000100000,
      S_M6   = 9'b001000000,
      S_SUM  = 9'b010000000,
      S_OUT  = 9'b100000000
   } pidaw_state_type;

   pidaw_state_type state_ff, state_in;

   logic signed [DATA_W-1:0]   gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [DATA_W-1:0]   limit_high_ff, limit_low_ff, output_scale_ff;
   logic [PERIOD_W-1:0]        sample_period_ff;
   logic [RATE_W-1:0]          sample_rate_ff;

   logic signed [DATA_W-1:0]   integral_ff, integral_in;
   logic signed [DATA_W-1:0]   prev_meas_ff, prev_meas_in;
   logic signed [DATA_W-1:0]   err_ff, err_in;
   logic signed [OP_W-1:0]     diff_ff, diff_in;
   logic signed [DATA_W-1:0]   delta_ff, delta_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   rsp_drive_ff, rsp_drive_in;

   logic                       accept;
   logic signed [DATA_W-1:0]   integ_sum;
   logic signed [DATA_W-1:0]   integ_clamped;
   logic signed [DATA_W-1:0]   out_sat;
   logic signed [DATA_W-1:0]   out_clamped;
   logic signed [DATA_W-1:0]   mul_result;
   pidaw_mul_req_type          mul_req;

   pidaw_mul_unit u_mul (
      .clock      (clock),
      .mul_req    (mul_req),
      .mul_result (mul_result)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff        <= '0;
         gain_i_ff        <= '0;
         gain_d_ff        <= '0;
         limit_high_ff    <= 32'sd65536;
         limit_low_ff     <= -32'sd65536;
         output_scale_ff  <= 32'sd65536;
         sample_period_ff <= 17'd655;
         sample_rate_ff   <= 16'd100;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN_P:        gain_p_ff        <= csr_wdata;
            CSR_GAIN_I:        gain_i_ff        <= csr_wdata;
            CSR_GAIN_D:        gain_d_ff        <= csr_wdata;
            CSR_LIMIT_HIGH:    limit_high_ff    <= csr_wdata;
            CSR_LIMIT_LOW:     limit_low_ff     <= csr_wdata;
            CSR_OUTPUT_SCALE:  output_scale_ff  <= csr_wdata;
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_SAMPLE_RATE:   sample_rate_ff   <= csr_wdata[RATE_W-1:0];
         endcase
      end
   end

   always_comb begin
      integ_sum = sat_acc(ACC_W'(integral_ff) + ACC_W'(mul_result));
      integ_clamped = integ_sum;
      if (integ_clamped > limit_high_ff) begin
         integ_clamped = limit_high_ff;
      end
      if (integ_clamped < limit_low_ff) begin
         integ_clamped = limit_low_ff;
      end

      out_sat = sat_acc(acc_ff);
      priority if (out_sat > limit_high_ff) begin
         out_clamped = limit_high_ff;
      end else if (out_sat < limit_low_ff) begin
         out_clamped = limit_low_ff;
      end else begin
         out_clamped = out_sat;
      end
   end

   always_comb begin
      state_in     = state_ff;
      integral_in  = integral_ff;
      prev_meas_in = prev_meas_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      delta_in     = delta_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_drive_in = rsp_drive_ff;
      mul_req      = '{load: 1'b0, shift: 1'b1, a: '0, b: '0};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               err_in       = sat_acc(ACC_W'(req_setpoint) - ACC_W'(req_measurement));
               diff_in      = OP_W'(req_measurement) - OP_W'(prev_meas_ff);
               prev_meas_in = req_measurement;
               state_in     = S_M1;
            end
         end
         S_M1: begin
            mul_req  = '{load: 1'b1, shift: 1'b1, a: OP_W'(err_ff),
                         b: OP_W'(signed'({1'b0, sample_period_ff}))};
            state_in = S_M2;
         end
         S_M2: begin
            integral_in = integ_clamped;
            mul_req  = '{load: 1'b1, shift: 1'b0, a: diff_ff,
                         b: OP_W'(signed'({1'b0, sample_rate_ff}))};
            state_in = S_M3;
         end
         S_M3: begin
            delta_in = mul_result;
            mul_req  = '{load: 1'b1, shift: 1'b1, a: OP_W'(gain_p_ff), b: OP_W'(err_ff)};
            state_in = S_M4;
         end
         S_M4: begin
            acc_in   = ACC_W'(mul_result);
            mul_req  = '{load: 1'b1, shift: 1'b1, a: OP_W'(gain_i_ff), b: OP_W'(integral_ff)};
            state_in = S_M5;
         end
         S_M5: begin
            acc_in   = acc_ff + ACC_W'(mul_result);
            mul_req  = '{load: 1'b1, shift: 1'b1, a: OP_W'(gain_d_ff), b: OP_W'(delta_ff)};
            state_in = S_M6;
         end
         S_M6: begin
            acc_in   = acc_ff - ACC_W'(mul_result);
            state_in = S_SUM;
         end
         S_SUM: begin
            mul_req  = '{load: 1'b1, shift: 1'b1, a: OP_W'(output_scale_ff),
                         b: OP_W'(out_clamped)};
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = mul_result;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         integral_ff  <= '0;
         prev_meas_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         integral_ff  <= integral_in;
         prev_meas_ff <= prev_meas_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      delta_ff     <= delta_in;
      acc_ff       <= acc_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_M1)
      else $error("accepted item did not start the sequence");

   a_integral_in_limits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_M2 |=> ($past(limit_low_ff) > $past(limit_high_ff)) ||
         (integral_ff <= $past(limit_high_ff) && integral_ff >= $past(limit_low_ff)))
      else $error("integral outside limits after update");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside the output step");

   a_busy_while_waiting: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && rsp_valid_ff && rsp_stall |=> state_ff == S_OUT && rsp_valid_ff)
      else $error("pending result lost");

endmodule

// ===== sim/pidaw_checker.sv =====
// Checker for the PID controller: tracks registers, predicts each drive value and compares.
module pidaw_checker
   import pidaw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_setpoint,
   input  logic signed [DATA_W-1:0] req_measurement,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_drive,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata,
   output int                       fail_count,
   output int                       pending,
   output int                       checked
);

   logic signed [DATA_W-1:0] kp, ki, kd, lim_hi, lim_lo, scale;
   logic [PERIOD_W-1:0]      period;
   logic [RATE_W-1:0]        rate;
   logic signed [DATA_W-1:0] integ_acc, last_meas;
   logic signed [DATA_W-1:0] drive_q [$];
   int                       errs = 0;
   int                       seen = 0;

   function automatic longint clamp32(input longint x);
      if (x > longint'(Q_MAX)) return longint'(Q_MAX);
      if (x < longint'(Q_MIN)) return longint'(Q_MIN);
      return x;
   endfunction

   function automatic longint fixmul(input longint a, input longint b);
      return clamp32((a * b) >>> FRAC_W);
   endfunction

   function automatic logic signed [DATA_W-1:0] next_drive(
      input logic signed [DATA_W-1:0] sp,
      input logic signed [DATA_W-1:0] ms
   );
      longint err, integ, delta, total;
      err   = clamp32(longint'(sp) - longint'(ms));
      integ = clamp32(longint'(integ_acc) + fixmul(err, longint'(period)));
      if (integ > longint'(lim_hi)) integ = longint'(lim_hi);
      if (integ < longint'(lim_lo)) integ = longint'(lim_lo);
      integ_acc = DATA_W'(integ);
      delta = clamp32((longint'(ms) - longint'(last_meas)) * longint'(rate));
      total = clamp32(fixmul(longint'(kp), err) + fixmul(longint'(ki), integ)
                      - fixmul(longint'(kd), delta));
      // with crossed limits, a value above the high limit takes it and every other value takes the low limit
      if (total > longint'(lim_hi)) begin
         total = longint'(lim_hi);
      end else if (total < longint'(lim_lo)) begin
         total = longint'(lim_lo);
      end
      last_meas = ms;
      return DATA_W'(fixmul(longint'(scale), total));
   endfunction

   always @(posedge clock) begin
      logic signed [DATA_W-1:0] want;
      if (reset) begin
         kp        = '0;
         ki        = '0;
         kd        = '0;
         lim_hi    = 32'sh0001_0000;
         lim_lo    = -32'sh0001_0000;
         scale     = 32'sh0001_0000;
         period    = PERIOD_W'(655);
         rate      = RATE_W'(100);
         integ_acc = '0;
         last_meas = '0;
         drive_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_GAIN_P:        kp     = csr_wdata;
               CSR_GAIN_I:        ki     = csr_wdata;
               CSR_GAIN_D:        kd     = csr_wdata;
               CSR_LIMIT_HIGH:    lim_hi = csr_wdata;
               CSR_LIMIT_LOW:     lim_lo = csr_wdata;
               CSR_OUTPUT_SCALE:  scale  = csr_wdata;
               CSR_SAMPLE_PERIOD: period = csr_wdata[PERIOD_W-1:0];
               CSR_SAMPLE_RATE:   rate   = csr_wdata[RATE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            drive_q.push_back(next_drive(req_setpoint, req_measurement));
         end
         if (rsp_valid && !rsp_stall) begin
            if (drive_q.size() == 0) begin
               errs++;
               if (errs <= 10) begin
                  $display("ERROR: drive %0d arrived with no item outstanding", rsp_drive);
               end
            end else begin
               want = drive_q.pop_front();
               seen++;
               if (rsp_drive !== want) begin
                  errs++;
                  if (errs <= 10) begin
                     $display("ERROR: drive mismatch, expected %0d (%h), got %0d (%h)",
                              want, want, rsp_drive, rsp_drive);
                  end
               end
            end
         end
      end
      fail_count <= errs;
      pending    <= drive_q.size();
      checked    <= seen;
   end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the PID controller: clock, reset, stimulus, idling and verdict.
module tb_top;
   import pidaw_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [CSR_IDX_W-1:0] REG_ORDER [8] = '{
      CSR_GAIN_P, CSR_GAIN_I, CSR_GAIN_D, CSR_LIMIT_HIGH,
      CSR_LIMIT_LOW, CSR_OUTPUT_SCALE, CSR_SAMPLE_PERIOD, CSR_SAMPLE_RATE
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_setpoint = '0;
   logic signed [DATA_W-1:0] req_measurement = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_drive;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   int                       fail_count;
   int                       pending;
   int                       checked;
   logic                     quiet = 1'b0;
   int                       stall_left = 0;
   int                       cycles = 0;
   int                       items_sent = 0;
   int                       settings_used = 0;
   logic signed [DATA_W-1:0] track_meas = '0;

   pid_controller_antiwindup_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_setpoint    (req_setpoint),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   pidaw_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_setpoint    (req_setpoint),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked         (checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("pid_controller_antiwindup_top verification failed");
         $finish;
      end
   end

   // hold the result channel in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic push_item(input logic signed [DATA_W-1:0] sp,
                            input logic signed [DATA_W-1:0] ms);
      req_setpoint    <= sp;
      req_measurement <= ms;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_regs(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] i,
                             input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] hi,
                             input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] sc,
                             input logic [DATA_W-1:0] per, input logic [DATA_W-1:0] rt);
      logic [DATA_W-1:0] vals [8];
      vals = '{p, i, d, hi, lo, sc, per, rt};
      drain();
      for (int k = 0; k < 8; k++) begin
         csr_index <= REG_ORDER[k];
         csr_wdata <= vals[k];
         csr_write <= 1'b1;
         @(posedge clock);
      end
      csr_write <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [DATA_W-1:0] pick_gain();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return DATA_W'($urandom_range(0, 1 << 19)) - DATA_W'(1 << 18);
   endfunction

   task automatic apply_random_regs();
      logic [DATA_W-1:0] hi, lo, sc, per, rt, swap;
      hi = DATA_W'($urandom_range(1 << 16, 1 << 24));
      lo = -DATA_W'($urandom_range(1 << 16, 1 << 24));
      case ($urandom_range(0, 5))
         0: begin
            swap = hi;
            hi   = lo;
            lo   = swap;
         end
         1: begin
            hi = $urandom;
            lo = $urandom;
         end
         default: ;
      endcase
      sc  = ($urandom_range(0, 3) == 0) ? $urandom
                                        : DATA_W'($urandom_range(0, 1 << 18)) - DATA_W'(1 << 17);
      per = ($urandom_range(0, 2) == 0) ? $urandom : DATA_W'($urandom_range(0, 2000));
      rt  = ($urandom_range(0, 2) == 0) ? $urandom : DATA_W'($urandom_range(0, 1000));
      apply_regs(pick_gain(), pick_gain(), pick_gain(), hi, lo, sc, per, rt);
   endtask

   // mostly a tracking loop with small steps; the rest wide, full-range and extreme values
   task automatic run_random(input int count);
      logic signed [DATA_W-1:0] sp, ms;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            6, 7: begin
               sp = DATA_W'($urandom_range(0, 1 << 25)) - DATA_W'(1 << 24);
               ms = DATA_W'($urandom_range(0, 1 << 25)) - DATA_W'(1 << 24);
            end
            8: begin
               sp = $urandom;
               ms = $urandom;
            end
            9: begin
               sp = ($urandom_range(0, 1) == 1) ? Q_MAX : Q_MIN;
               ms = ($urandom_range(0, 1) == 1) ? Q_MIN : -32'sd1;
            end
            default: begin
               sp = DATA_W'($urandom_range(0, 1 << 20)) - DATA_W'(1 << 19);
               track_meas = track_meas + DATA_W'($urandom_range(0, 16384)) - DATA_W'(8192);
               if (track_meas > 32'sh0010_0000 || track_meas < -32'sh0010_0000) begin
                  track_meas = '0;
               end
               ms = track_meas;
            end
         endcase
         push_item(sp, ms);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // typical loop: unit P, half I, small D, limits of +/-100
      apply_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'h0064_0000,
                 32'hFF9C_0000, 32'h0001_0000, 32'd655, 32'd100);
      push_item(32'sh0000_0000, 32'sh0000_0000);
      push_item(32'sh0001_0000, 32'sh0000_0000);
      push_item(Q_MAX, Q_MIN);
      push_item(Q_MIN, Q_MAX);
      push_item(Q_MAX, Q_MAX);
      push_item(Q_MIN, Q_MIN);
      push_item(-32'sd1, 32'sh0000_0000);
      push_item(32'sh0000_0000, -32'sd1);
      push_item(Q_MAX, 32'sh0000_0000);
      push_item(32'sh0000_0000, Q_MAX);
      push_item(32'sh0064_0000, 32'sh0000_0000);
      push_item(32'sh0064_0000, 32'sh0000_0000);
      req_valid <= 1'b0;

      // extremes; period and rate words carry bits above their width
      apply_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(Q_MAX, Q_MIN);
      push_item(Q_MIN, Q_MAX);
      push_item(32'sh0000_0001, 32'sh0000_0000);
      push_item(32'sh0000_0000, 32'sh0000_0000);
      push_item(32'sh5555_5555, 32'shAAAA_AAAA);
      req_valid <= 1'b0;

      // crossed limits with zero sample period and zero rate
      apply_regs(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                 32'h0001_0000, 32'h0000_8000, 32'd0, 32'd0);
      push_item(32'sh0000_0000, 32'sh0000_0000);
      push_item(32'sh0010_0000, 32'sh0000_0000);
      push_item(-32'sh0010_0000, 32'sh0000_0000);
      push_item(Q_MAX, Q_MIN);
      push_item(Q_MIN, Q_MIN);
      req_valid <= 1'b0;
      run_random(60);

      // zero gains and zero-width limits, period of exactly one second
      apply_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 32'h0000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'd1);
      run_random(60);

      apply_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h0001_FFFF, 32'h0000_FFFF);
      run_random(60);

      for (int ph = 0; ph < 7; ph++) begin
         if (ph == 6) begin
            quiet <= 1'b1;
         end
         apply_random_regs();
         run_random(140);
      end

      drain();
      $display("Sent %0d items, checked %0d drive values over %0d register settings,",
               items_sent, checked, settings_used);
      $display("including saturating gains, crossed limits, zero rate and wide periods.");
      if (fail_count == 0 && pending == 0) begin
         $display("pid_controller_antiwindup_top verification clean");
      end else begin
         $display("pid_controller_antiwindup_top verification failed");
      end
      $finish;
   end

endmodule
